/* rtl/trie_pkg.sv */
// Shared constants and command codes of the trie word store.
`default_nettype none

package trie_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 26;

    localparam int CMD_W       = 2;
    localparam int LETTER_W    = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;
    localparam int ALPHA_CMP_W = 9;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

endpackage

`default_nettype wire

/* rtl/trie_word_store.sv */
// Top level of the trie word store: letter walk, node allocation and word marks.
// For an item that is not the last of its word, the accept cycle issues the child link read
// and the next cycle follows or allocates the link.
// For the last item of a word, the walk state also reads the word mark; the final state,
// once the output is free, writes the mark on an insert and registers the result.
// After reset both memories are cleared in one pass over the NODES*ALPHABET link
// addresses while s_tready stays low.
`default_nettype none

module trie_word_store #(
    parameter int NODES    = trie_pkg::NODES_DEF,
    parameter int ALPHABET = trie_pkg::ALPHABET_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd [1:0], letter [6:2], has_letter [7]
    input  wire logic [trie_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // found [0], pool_full [1], zero fill [7:2]
    output logic      [trie_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int NW    = $clog2(NODES);
    localparam int NFW   = $clog2(NODES + 1);
    localparam int DEPTH = NODES * ALPHABET;
    localparam int CW    = $clog2(DEPTH);

    localparam logic [CW-1:0]  CLR_LAST = CW'(DEPTH - 1);
    localparam logic [CW-1:0]  NODES_CW = CW'(NODES);
    localparam logic [NFW-1:0] NODES_NF = NFW'(NODES);
    localparam logic [trie_pkg::ALPHA_CMP_W-1:0] ALPHA_C =
        trie_pkg::ALPHA_CMP_W'(ALPHABET);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                clr_reg, clr_next;
    logic [NW-1:0]                cursor_reg, cursor_next;
    logic [NFW-1:0]               free_reg, free_next;
    logic                         missed_reg, missed_next;
    logic                         ovf_reg, ovf_next;
    logic [trie_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic                         last_reg, last_next;
    logic                         walk_reg, walk_next;
    logic [CW-1:0]                addr_reg, addr_next;
    logic                         m_valid_reg, m_valid_next;
    logic [trie_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [trie_pkg::CMD_W-1:0]    in_cmd;
    logic [trie_pkg::LETTER_W-1:0] in_letter;
    logic                          in_has;
    logic                          letter_ok;
    logic [CW-1:0]                 walk_addr;

    logic          link_en, link_we;
    logic [CW-1:0] link_addr;
    logic [NW-1:0] link_wdata, link_rdata;
    logic          mark_en, mark_we, mark_wdata, mark_rdata;
    logic [NW-1:0] mark_addr;

    logic out_free, ok, found;

    assign in_cmd    = s_tdata[1:0];
    assign in_letter = s_tdata[6:2];
    assign in_has    = s_tdata[7];
    assign letter_ok = {4'b0, in_letter} < ALPHA_C;
    assign walk_addr = CW'(cursor_reg) * CW'(ALPHABET) + CW'(in_letter);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign ok       = !missed_reg && !ovf_reg;

    always_comb begin
        found = ok;
        if (cmd_reg == trie_pkg::CMD_EXACT) begin
            found = ok && ((cursor_reg == '0) || mark_rdata);
        end
    end

    trie_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_links (
        .aclk  (aclk),
        .en    (link_en),
        .we    (link_we),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    trie_ram #(.WIDTH(1), .DEPTH(NODES)) u_marks (
        .aclk  (aclk),
        .en    (mark_en),
        .we    (mark_we),
        .addr  (mark_addr),
        .wdata (mark_wdata),
        .rdata (mark_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cursor_next  = cursor_reg;
        free_next    = free_reg;
        missed_next  = missed_reg;
        ovf_next     = ovf_reg;
        cmd_next     = cmd_reg;
        last_next    = last_reg;
        walk_next    = walk_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        link_en    = 1'b0;
        link_we    = 1'b0;
        link_addr  = addr_reg;
        link_wdata = free_reg[NW-1:0];
        mark_en    = 1'b0;
        mark_we    = 1'b0;
        mark_addr  = cursor_reg;
        mark_wdata = 1'b1;

        unique case (state_reg)
            ST_CLEAR: begin
                link_en    = 1'b1;
                link_we    = 1'b1;
                link_addr  = clr_reg;
                link_wdata = '0;
                mark_en    = clr_reg < NODES_CW;
                mark_we    = clr_reg < NODES_CW;
                mark_addr  = clr_reg[NW-1:0];
                mark_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    last_next  = s_tlast;
                    addr_next  = walk_addr;
                    walk_next  = in_has && ok && letter_ok;
                    link_en    = in_has && ok && letter_ok;
                    link_addr  = walk_addr;
                    state_next = ST_WALK;
                    if (in_has && ok && !letter_ok) begin
                        missed_next = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                if (walk_reg) begin
                    if (link_rdata != '0) begin
                        cursor_next = link_rdata;
                    end else if (cmd_reg != trie_pkg::CMD_INSERT) begin
                        missed_next = 1'b1;
                    end else if (free_reg >= NODES_NF) begin
                        ovf_next = 1'b1;
                    end else begin
                        link_en     = 1'b1;
                        link_we     = 1'b1;
                        cursor_next = free_reg[NW-1:0];
                        free_next   = free_reg + 1'b1;
                    end
                end
                if (last_reg) begin
                    mark_en    = 1'b1;
                    mark_addr  = cursor_next;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (cmd_reg == trie_pkg::CMD_INSERT && ok && cursor_reg != '0) begin
                        mark_en = 1'b1;
                        mark_we = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, ovf_reg, found};
                    cursor_next  = '0;
                    missed_next  = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cursor_reg  <= '0;
            free_reg    <= NFW'(1);
            missed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cursor_reg  <= cursor_next;
            free_reg    <= free_next;
            missed_reg  <= missed_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        last_reg   <= last_next;
        walk_reg   <= walk_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

/* rtl/trie_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module trie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire
